// ===== design/ectc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch-to-calendar shared definitions
// Field widths, reciprocal constants for the constant divisions, small lookup
// tables and the structs that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package ectc_pkg;

  // Field widths.
  localparam int EPOCH_W   = 32;
  localparam int OFFSET_W  = 5;
  localparam int YEAR_W    = 12;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int SECOND_W  = 6;
  localparam int WEEKDAY_W = 3;
  localparam int DAYS_W    = 16;

  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 5'sd3;

  localparam int SEC_PER_HOUR  = 3600;
  localparam int SEC_PER_MIN   = 60;
  localparam int MIN_PER_HOUR  = 60;
  localparam int HOURS_PER_DAY = 24;

  // Division by a constant d is floor(n * ceil(2^k / d) / 2^k). The shift k
  // is chosen so that n_max * (M*d - 2^k) < 2^k, which makes it exact.
  localparam int DIV60_SH = 37;
  localparam logic [31:0] DIV60_MUL =
    32'(((64'd1 << DIV60_SH) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN));
  localparam int DIV24_SH = 26;
  localparam logic [21:0] DIV24_MUL =
    22'(((64'd1 << DIV24_SH) + 64'(HOURS_PER_DAY) - 64'd1) / 64'(HOURS_PER_DAY));

  // Julian-day chain constants.
  localparam int GREG_CYCLE  = 146097;
  localparam int GREG_BIAS   = 102032;
  localparam int JD_OFFSET   = 2442113;
  // For a 16-bit day count the century term is 15, 16 or 17, so the leap
  // correction a - a/4 is 12 below this day count and 13 from it on.
  localparam int ADJ_DAYS    = (2 * GREG_CYCLE - GREG_BIAS + 3) / 4;
  localparam int ADJ_LOW     = 12;
  localparam int ADJ_HIGH    = 13;
  localparam int YEAR_BIAS   = 2442;
  localparam int YEAR_DIV    = 7305;
  localparam int YEAR_SCALE  = 20;
  localparam int DAYS_PER_YEAR = 365;
  localparam int DIVY_SH     = 39;
  localparam logic [63:0] DIVY_MUL =
    ((64'd1 << DIVY_SH) + 64'(YEAR_DIV) - 64'd1) / 64'(YEAR_DIV);
  // (20*b - 2442) * M folded into b * (20*M) - 2442*M.
  localparam logic [30:0] DIVY_MUL20 = 31'(64'(YEAR_SCALE) * DIVY_MUL);
  localparam logic [52:0] DIVY_BIAS  = 53'(64'(YEAR_BIAS) * DIVY_MUL);
  localparam int MONTH_DIV   = 30601;
  localparam int MONTH_SCALE = 1000;
  localparam int DIVM_SH     = 35;
  // d * 1000 / 30601 with the factor 1000 folded into the reciprocal.
  localparam logic [30:0] DIVM_MUL = 31'(64'(MONTH_SCALE) *
    (((64'd1 << DIVM_SH) + 64'(MONTH_DIV) - 64'd1) / 64'(MONTH_DIV)));
  localparam int DAYS_PER_MONTH_BASE = 30;
  localparam int YEAR_BASE_LO = 4716;
  localparam int YEAR_BASE_HI = 4715;
  localparam int MONTH_E_LAST = 13;
  localparam int MONTHS_PER_YEAR = 12;
  localparam int FEB = 2;

  // Weekday constants.
  localparam int DIV100_SH = 19;
  localparam logic [12:0] DIV100_MUL = 13'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);
  localparam int CENTURY = 100;
  localparam int ZELLER_CEN_MUL = 5;
  localparam int ZELLER_BIAS = 5;
  localparam int DAYS_PER_WEEK = 7;

  // floor(601 * e / 1000) for e = 0..15.
  localparam logic [3:0] MONTH_FRAC [16] = '{
    4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd3, 4'd3, 4'd4,
    4'd4, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd9
  };

  // floor(26 * (m + 1) / 10) for m = 0..15.
  localparam logic [5:0] ZELLER_MONTH [16] = '{
    6'd2,  6'd5,  6'd7,  6'd10, 6'd13, 6'd15, 6'd18, 6'd20,
    6'd23, 6'd26, 6'd28, 6'd31, 6'd33, 6'd36, 6'd39, 6'd41
  };

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } tod_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    tod_t              tod;
  } split_t;

  typedef struct packed {
    date_t              date;
    tod_t               tod;
    logic [MONTH_W-1:0] z_month;
    logic [YEAR_W-1:0]  z_year;
  } civil_t;

  typedef struct packed {
    date_t                date;
    tod_t                 tod;
    logic [WEEKDAY_W-1:0] weekday;
  } result_t;

endpackage

// ===== design/ectc_time_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch-to-calendar time split
// Adds the zone shift and splits seconds into a day count and time of day
// over five stages; the divisions by 60 and 24 use reciprocal multiplies.
// ----------------------------------------------------------------------------
module ectc_time_split (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [ectc_pkg::OFFSET_W-1:0]  offset_i,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [ectc_pkg::EPOCH_W-1:0]          epoch_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output ectc_pkg::split_t                      data_o
);
  import ectc_pkg::*;

  localparam int STAGES    = 5;
  localparam int MIN_TOT_W = 27;
  localparam int HR_TOT_W  = 21;

  logic [STAGES-1:0]    v_q;
  logic [STAGES-1:0]    en;
  logic [EPOCH_W-1:0]   shift;
  logic [EPOCH_W-1:0]   t_d, t_q;
  logic [63:0]          p1, p2;
  logic [MIN_TOT_W-1:0] q1_d, q1_q;
  logic [SECOND_W-1:0]  t6_q;
  logic [HR_TOT_W-1:0]  q2_d, q2_q;
  logic [11:0]          m60a, m60b;
  logic [SECOND_W-1:0]  sec_d, sec3_q, sec4_q;
  logic [MINUTE_W-1:0]  q1lo_q, min_d, min4_q;
  logic [42:0]          p3;
  logic [DAYS_W-1:0]    days_d, days_q;
  logic [HOUR_W-1:0]    q2lo_q, hr_d;
  logic [DAYS_W+4:0]    d24;
  split_t               out_q;

  // Each stage moves when it is empty or the one after it moves.
  always_comb begin
    en[STAGES-1] = ~v_q[STAGES-1] | ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Offset times 3600, sign extended and taken modulo 2^32.
  assign shift  = EPOCH_W'(offset_i * SEC_PER_HOUR);
  assign t_d    = epoch_i + shift;

  assign p1     = {32'd0, t_q} * {32'd0, DIV60_MUL};
  assign q1_d   = p1[DIV60_SH +: MIN_TOT_W];

  assign p2     = {37'd0, q1_q} * {32'd0, DIV60_MUL};
  assign q2_d   = p2[DIV60_SH +: HR_TOT_W];
  // The remainder is below 64, so the low six bits are enough.
  assign m60a   = {6'd0, q1_q[SECOND_W-1:0]} * 12'(SEC_PER_MIN);
  assign sec_d  = t6_q - m60a[SECOND_W-1:0];

  assign p3     = {22'd0, q2_q} * {21'd0, DIV24_MUL};
  assign days_d = p3[DIV24_SH +: DAYS_W];
  assign m60b   = {6'd0, q2_q[MINUTE_W-1:0]} * 12'(MIN_PER_HOUR);
  assign min_d  = q1lo_q - m60b[MINUTE_W-1:0];

  assign d24    = (DAYS_W+5)'(days_q) * (DAYS_W+5)'(HOURS_PER_DAY);
  assign hr_d   = q2lo_q - d24[HOUR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t_q <= t_d;
    end
    if (en[1]) begin
      q1_q <= q1_d;
      t6_q <= t_q[SECOND_W-1:0];
    end
    if (en[2]) begin
      q2_q   <= q2_d;
      sec3_q <= sec_d;
      q1lo_q <= q1_q[MINUTE_W-1:0];
    end
    if (en[3]) begin
      days_q <= days_d;
      min4_q <= min_d;
      sec4_q <= sec3_q;
      q2lo_q <= q2_q[HOUR_W-1:0];
    end
    if (en[4]) begin
      out_q.days       <= days_q;
      out_q.tod.hour   <= hr_d;
      out_q.tod.minute <= min4_q;
      out_q.tod.second <= sec4_q;
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[STAGES-1];
  assign data_o  = out_q;

endmodule

// ===== design/ectc_date_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch-to-calendar date chain
// Turns the day count into year, month and day of month over five stages and
// prepares the shifted month and year used by the weekday formula.
// ----------------------------------------------------------------------------
module ectc_date_calc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  ectc_pkg::split_t  data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ectc_pkg::civil_t  data_o
);
  import ectc_pkg::*;

  localparam int STAGES = 5;
  localparam int B_W    = 22;
  localparam int C_W    = 13;
  localparam int D_W    = 9;
  localparam int E_W    = 4;

  logic [STAGES-1:0]  v_q;
  logic [STAGES-1:0]  en;
  logic [3:0]         adj;
  logic [B_W-1:0]     b_d, b1_q, b2_q;
  logic [52:0]        pc;
  logic [C_W-1:0]     c_d, c2_q, c3_q, c4_q;
  logic [B_W-1:0]     d_full;
  logic [D_W-1:0]     d_d, d3_q, d4_q;
  logic [39:0]        pe;
  logic [E_W-1:0]     e_d, e4_q;
  logic [D_W-1:0]     f_full;
  logic [YEAR_W-1:0]  year_d, zy_d;
  logic [MONTH_W-1:0] month_d, zm_d;
  tod_t               tod1_q, tod2_q, tod3_q, tod4_q;
  civil_t             out_q;

  always_comb begin
    en[STAGES-1] = ~v_q[STAGES-1] | ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign adj    = (data_i.days >= DAYS_W'(ADJ_DAYS)) ? 4'(ADJ_HIGH) : 4'(ADJ_LOW);
  assign b_d    = B_W'(data_i.days) + B_W'(JD_OFFSET) + B_W'(adj);

  assign pc     = 53'(b1_q) * 53'(DIVY_MUL20) - DIVY_BIAS;
  assign c_d    = pc[DIVY_SH +: C_W];

  assign d_full = b2_q - B_W'(c2_q) * B_W'(DAYS_PER_YEAR) - B_W'(c2_q >> 2);
  assign d_d    = d_full[D_W-1:0];

  assign pe     = 40'(d3_q) * 40'(DIVM_MUL);
  assign e_d    = pe[DIVM_SH +: E_W];

  assign f_full = d4_q - D_W'(e4_q) * D_W'(DAYS_PER_MONTH_BASE) - D_W'(MONTH_FRAC[e4_q]);

  always_comb begin
    if (e4_q <= E_W'(MONTH_E_LAST)) begin
      year_d  = YEAR_W'(c4_q - C_W'(YEAR_BASE_LO));
      month_d = e4_q - 4'd1;
    end else begin
      year_d  = YEAR_W'(c4_q - C_W'(YEAR_BASE_HI));
      month_d = e4_q - E_W'(MONTH_E_LAST);
    end
    // January and February count as months 13 and 14 of the year before.
    if (month_d <= MONTH_W'(FEB)) begin
      zm_d = month_d + MONTH_W'(MONTHS_PER_YEAR);
      zy_d = year_d - 12'd1;
    end else begin
      zm_d = month_d;
      zy_d = year_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      b1_q   <= b_d;
      tod1_q <= data_i.tod;
    end
    if (en[1]) begin
      c2_q   <= c_d;
      b2_q   <= b1_q;
      tod2_q <= tod1_q;
    end
    if (en[2]) begin
      d3_q   <= d_d;
      c3_q   <= c2_q;
      tod3_q <= tod2_q;
    end
    if (en[3]) begin
      e4_q   <= e_d;
      d4_q   <= d3_q;
      c4_q   <= c3_q;
      tod4_q <= tod3_q;
    end
    if (en[4]) begin
      out_q.date.year  <= year_d;
      out_q.date.month <= month_d;
      out_q.date.day   <= f_full[DAY_W-1:0];
      out_q.tod        <= tod4_q;
      out_q.z_month    <= zm_d;
      out_q.z_year     <= zy_d;
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[STAGES-1];
  assign data_o  = out_q;

endmodule

// ===== design/ectc_weekday.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch-to-calendar weekday
// Zeller's congruence over three stages; the final stage is the output
// register of the block.
// ----------------------------------------------------------------------------
module ectc_weekday (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  ectc_pkg::civil_t  data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ectc_pkg::result_t data_o
);
  import ectc_pkg::*;

  localparam int STAGES = 3;
  localparam int CEN_W  = 5;
  localparam int YY_W   = 7;
  localparam int H_W    = 9;

  logic [STAGES-1:0] v_q;
  logic [STAGES-1:0] en;
  logic [24:0]       pcen;
  logic [CEN_W-1:0]  cen_d, cen1_q;
  logic [5:0]        zt1_q;
  logic [YY_W-1:0]   zyl1_q, yy;
  logic [11:0]       c100;
  logic [H_W-1:0]    h_d, h2_q, n;
  logic [4:0]        s1;
  logic [3:0]        s2;
  logic [2:0]        r;
  date_t             date1_q, date2_q;
  tod_t              tod1_q, tod2_q;
  result_t           out_q;

  always_comb begin
    en[STAGES-1] = ~v_q[STAGES-1] | ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign pcen  = 25'(data_i.z_year) * 25'(DIV100_MUL);
  assign cen_d = pcen[DIV100_SH +: CEN_W];

  assign c100  = 12'(cen1_q) * 12'(CENTURY);
  assign yy    = zyl1_q - c100[YY_W-1:0];
  assign h_d   = H_W'(date1_q.day) + H_W'(zt1_q) + H_W'(yy) + H_W'(yy >> 2)
               + H_W'(cen1_q) * H_W'(ZELLER_CEN_MUL) + H_W'(cen1_q >> 2);

  // Modulo 7 by folding octal digits, since 8 is 1 modulo 7.
  assign n  = h2_q + H_W'(ZELLER_BIAS);
  assign s1 = 5'(n[2:0]) + 5'(n[5:3]) + 5'(n[8:6]);
  assign s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
  assign r  = (s2 >= 4'(DAYS_PER_WEEK)) ? 3'(s2 - 4'(DAYS_PER_WEEK)) : s2[2:0];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cen1_q  <= cen_d;
      zt1_q   <= ZELLER_MONTH[data_i.z_month];
      zyl1_q  <= data_i.z_year[YY_W-1:0];
      date1_q <= data_i.date;
      tod1_q  <= data_i.tod;
    end
    if (en[1]) begin
      h2_q    <= h_d;
      date2_q <= date1_q;
      tod2_q  <= tod1_q;
    end
    if (en[2]) begin
      out_q.date    <= date2_q;
      out_q.tod     <= tod2_q;
      out_q.weekday <= r + 3'd1;
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[STAGES-1];
  assign data_o  = out_q;

endmodule

// ===== design/epoch_seconds_to_calendar_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar unit
// Converts a 32-bit Unix seconds count, shifted by a whole-hour zone offset,
// into local year, month, day, hour, minute, second and ISO weekday.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                  Payload
//   --------  -------------------------  -------------------------------------
//   config    cfg_we_i                   cfg_wdata_i (signed hours, reset 3)
//   request   in_valid_i / in_ready_o    epoch_seconds_i
//   result    out_valid_o / out_ready_i  year_o month_o day_of_month_o hour_o
//                                        minute_o second_o weekday_o
//
// Thirteen register stages: five split the seconds into days and time of
// day, five run the Julian-day chain and three compute the weekday.
// A request can be taken every cycle unless a stalled result has backed the
// pipeline up; its result reaches the ports after passing every stage.
// Reset empties every stage and sets the offset to +3 hours.
// A stalled result holds only full stages; empty ones in front keep filling.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic signed [ectc_pkg::OFFSET_W-1:0]  cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [ectc_pkg::EPOCH_W-1:0]          epoch_seconds_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [ectc_pkg::YEAR_W-1:0]           year_o,
  output logic [ectc_pkg::MONTH_W-1:0]          month_o,
  output logic [ectc_pkg::DAY_W-1:0]            day_of_month_o,
  output logic [ectc_pkg::HOUR_W-1:0]           hour_o,
  output logic [ectc_pkg::MINUTE_W-1:0]         minute_o,
  output logic [ectc_pkg::SECOND_W-1:0]         second_o,
  output logic [ectc_pkg::WEEKDAY_W-1:0]        weekday_o
);
  import ectc_pkg::*;

  logic signed [OFFSET_W-1:0] offset_q;
  logic                       split_valid, split_ready;
  logic                       date_valid, date_ready;
  split_t                     split_data;
  civil_t                     date_data;
  result_t                    result;

  // The user must write the offset only while the pipeline is empty, so every
  // request in flight sees the same value; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // Seconds plus zone shift, then minutes, hours and whole days.
  ectc_time_split u_split (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .offset_i (offset_q),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .epoch_i  (epoch_seconds_i),
    .valid_o  (split_valid),
    .ready_i  (split_ready),
    .data_o   (split_data)
  );

  // Day count to year, month and day of month.
  ectc_date_calc u_date (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .ready_o (split_ready),
    .data_i  (split_data),
    .valid_o (date_valid),
    .ready_i (date_ready),
    .data_o  (date_data)
  );

  // Weekday; its last stage doubles as the output register.
  ectc_weekday u_weekday (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (date_valid),
    .ready_o (date_ready),
    .data_i  (date_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (result)
  );

  assign year_o         = result.date.year;
  assign month_o        = result.date.month;
  assign day_of_month_o = result.date.day;
  assign hour_o         = result.tod.hour;
  assign minute_o       = result.tod.minute;
  assign second_o       = result.tod.second;
  assign weekday_o      = result.weekday;

endmodule

// ===== design/ectc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch-to-calendar port checker
// Watches the top-level ports for handshake and result range violations.
// ----------------------------------------------------------------------------
module ectc_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic [ectc_pkg::YEAR_W-1:0]           year_o,
  input logic [ectc_pkg::MONTH_W-1:0]          month_o,
  input logic [ectc_pkg::DAY_W-1:0]            day_of_month_o,
  input logic [ectc_pkg::HOUR_W-1:0]           hour_o,
  input logic [ectc_pkg::MINUTE_W-1:0]         minute_o,
  input logic [ectc_pkg::SECOND_W-1:0]         second_o,
  input logic [ectc_pkg::WEEKDAY_W-1:0]        weekday_o
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(year_o) && $stable(month_o)
      && $stable(day_of_month_o) && $stable(hour_o) && $stable(minute_o)
      && $stable(second_o) && $stable(weekday_o))
    else $error("stalled result changed");

  // Requests are refused only when the whole pipeline is backed up.
  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused while the result side is moving");

  // Every result field is within its calendar range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> year_o >= 1970 && year_o <= 2106 && month_o >= 1
      && month_o <= 12 && day_of_month_o >= 1 && hour_o < 24 && minute_o < 60
      && second_o < 60 && weekday_o >= 1 && weekday_o <= 7)
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_unit ectc_checker u_checker (.*);
